/* design/usm_pkg.sv */
// Shared constants, types and arithmetic helpers for the unsharp mask pixel unit.
`timescale 1ns / 1ps

package usm_pkg;

  // Color coefficients, signed, in units of 1/4096
  localparam logic signed [13:0] K_Y_R  = 14'sd1225;
  localparam logic signed [13:0] K_Y_G  = 14'sd2404;
  localparam logic signed [13:0] K_Y_B  = 14'sd467;
  localparam logic signed [13:0] K_CB_R = -14'sd692;
  localparam logic signed [13:0] K_CB_G = -14'sd1356;
  localparam logic signed [13:0] K_CB_B = 14'sd2048;
  localparam logic signed [13:0] K_CR_R = 14'sd2048;
  localparam logic signed [13:0] K_CR_G = -14'sd1716;
  localparam logic signed [13:0] K_CR_B = -14'sd332;
  localparam logic signed [13:0] K_R_CR = 14'sd5734;
  localparam logic signed [13:0] K_G_CB = 14'sd1405;
  localparam logic signed [13:0] K_G_CR = 14'sd2912;
  localparam logic signed [13:0] K_B_CB = 14'sd7229;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned GAIN_BITS = 8;

  // Chroma offset, plain and scaled by 4096
  localparam logic [7:0]         CHROMA_OFS    = 8'd127;
  localparam logic signed [23:0] CHROMA_OFS_SC = 24'sd520192;

  // Register indexes of the config port
  localparam logic CFG_GAIN      = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic [11:0] GAIN_RESET      = 12'd256;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd0;

  // Side data that rides along with each pixel
  typedef struct packed {
    logic       sharp;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } usm_meta_t;

  // Unsigned 8-bit sample times signed coefficient
  function automatic logic signed [21:0] mul_px(input logic [7:0] x,
                                                input logic signed [13:0] k);
    logic signed [21:0] xe;
    logic signed [21:0] ke;
    xe = $signed({14'b0, x});
    ke = 22'(k);
    return xe * ke;
  endfunction

  // Signed chroma difference times signed coefficient
  function automatic logic signed [23:0] mul_ch(input logic signed [8:0] d,
                                                input logic signed [13:0] k);
    logic signed [23:0] de;
    logic signed [23:0] ke;
    de = 24'(d);
    ke = 24'(k);
    return de * ke;
  endfunction

  // Divide by 2^sh, round half away from zero, clip to 0..255.
  // Negative inputs always land at or below zero, so they clip to 0.
  function automatic logic [7:0] rnd_clip(input logic signed [23:0] v,
                                          input int unsigned sh);
    logic signed [23:0] half;
    logic signed [23:0] q;
    half = 24'sd1 <<< (sh - 1);
    q    = (v + half) >>> sh;
    if (v < 0) begin
      return 8'd0;
    end else if (q > 24'sd255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

endpackage

/* design/unsharp_mask_ycbcr_pixel_unit.sv */
// Top level of the unsharp mask pixel unit: luma sharpening in YCbCr space.
`timescale 1ns / 1ps

// Unsharp mask, one RGB pixel per beat. Pulse start with the original pixel,
// its blurred version and the gradient magnitude; busy is always low, so a
// new beat may be issued on every clock. The result is loaded into the output
// register and sits on out_red/out_green/out_blue/sharpened for exactly one
// cycle with done high. There is no backpressure: the receiver must take every
// result as it comes. Throughput is one pixel per clock; the 8-stage pipeline
// (forward color products, sums, round/clip, gain multiply, luma round/clip,
// then back-conversion products, sums, round/clip) only sets the latency.
// Pixels whose gradient is below gradient_threshold come out unchanged with
// sharpened low, at the same latency. Write sharpen_gain (index 0, Q4.8)
// and gradient_threshold (index 1) only while no pixel is in flight.

module unsharp_mask_ycbcr_pixel_unit import usm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  orig_red,
  input  logic [7:0]  orig_green,
  input  logic [7:0]  orig_blue,
  input  logic [7:0]  blur_red,
  input  logic [7:0]  blur_green,
  input  logic [7:0]  blur_blue,
  input  logic [7:0]  grad_mag,
  // config write port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  // result side
  output logic        done,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        sharpened
);

  logic [11:0] sharpen_gain;
  logic [7:0]  gradient_threshold;
  logic        accept;

  // fully pipelined, never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sharpen_gain       <= GAIN_RESET;
      gradient_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GAIN:      sharpen_gain       <= cfg_data;
        CFG_THRESHOLD: gradient_threshold <= cfg_data[7:0];
        default:       ;
      endcase
    end
  end

  // Stage 1: constant products for original Y/Cb/Cr and blurred Y.
  // Blurred chroma never feeds the result, so it is not computed.
  logic               v1;
  usm_meta_t          m1;
  logic signed [21:0] yo_r, yo_g, yo_b;
  logic signed [21:0] cb_r, cb_g, cb_b;
  logic signed [21:0] cr_r, cr_g, cr_b;
  logic signed [21:0] yb_r, yb_g, yb_b;

  // Stage 2: dot-product sums (luma sums non-negative by range, chroma sums can be negative)
  logic               v2;
  usm_meta_t          m2;
  logic signed [23:0] s_yo, s_cb, s_cr, s_yb;

  // Stage 3: round/clip to 8 bits, luma mask
  logic               v3;
  usm_meta_t          m3;
  logic [7:0]         yo3, cbo3, cro3;
  logic signed [8:0]  mask3;

  // Stage 4: gain times mask, chroma offsets removed
  logic               v4;
  usm_meta_t          m4;
  logic [7:0]         yo4;
  logic signed [21:0] gm4;
  logic signed [8:0]  dcb4, dcr4;

  // Stage 5: new luma
  logic               v5;
  usm_meta_t          m5;
  logic [7:0]         ynew5;
  logic signed [8:0]  dcb5, dcr5;

  logic signed [12:0] gain_s;
  logic signed [23:0] luma_acc;

  assign gain_s   = $signed({1'b0, sharpen_gain});
  assign luma_acc = $signed(24'({yo4, 8'b0})) + 24'(gm4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    // threshold is inclusive: equal gradient gets sharpened
    m1.sharp <= (grad_mag >= gradient_threshold);
    m1.red   <= orig_red;
    m1.green <= orig_green;
    m1.blue  <= orig_blue;
    yo_r <= mul_px(orig_red,   K_Y_R);
    yo_g <= mul_px(orig_green, K_Y_G);
    yo_b <= mul_px(orig_blue,  K_Y_B);
    cb_r <= mul_px(orig_red,   K_CB_R);
    cb_g <= mul_px(orig_green, K_CB_G);
    cb_b <= mul_px(orig_blue,  K_CB_B);
    cr_r <= mul_px(orig_red,   K_CR_R);
    cr_g <= mul_px(orig_green, K_CR_G);
    cr_b <= mul_px(orig_blue,  K_CR_B);
    yb_r <= mul_px(blur_red,   K_Y_R);
    yb_g <= mul_px(blur_green, K_Y_G);
    yb_b <= mul_px(blur_blue,  K_Y_B);

    m2   <= m1;
    s_yo <= 24'(yo_r) + 24'(yo_g) + 24'(yo_b);
    s_cb <= 24'(cb_r) + 24'(cb_g) + 24'(cb_b) + CHROMA_OFS_SC;
    s_cr <= 24'(cr_r) + 24'(cr_g) + 24'(cr_b) + CHROMA_OFS_SC;
    s_yb <= 24'(yb_r) + 24'(yb_g) + 24'(yb_b);

    m3    <= m2;
    yo3   <= rnd_clip(s_yo, FRAC_BITS);
    cbo3  <= rnd_clip(s_cb, FRAC_BITS);
    cro3  <= rnd_clip(s_cr, FRAC_BITS);
    mask3 <= $signed({1'b0, rnd_clip(s_yo, FRAC_BITS)})
           - $signed({1'b0, rnd_clip(s_yb, FRAC_BITS)});

    m4   <= m3;
    yo4  <= yo3;
    gm4  <= 22'(gain_s) * 22'(mask3);
    dcb4 <= $signed({1'b0, cbo3}) - $signed({1'b0, CHROMA_OFS});
    dcr4 <= $signed({1'b0, cro3}) - $signed({1'b0, CHROMA_OFS});

    m5    <= m4;
    ynew5 <= rnd_clip(luma_acc, GAIN_BITS);
    dcb5  <= dcb4;
    dcr5  <= dcr4;
  end

  // Stages 6..8: back to RGB, final select and output register
  usm_ycc_to_rgb u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_meta   (m5),
    .luma      (ynew5),
    .dcb       (dcb5),
    .dcr       (dcr5),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .sharpened (sharpened)
  );

  // a result only ever follows an accepted beat
  a_done_has_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 8))
    else $error("result without a matching command");

  // sharpened flag matches the threshold test made at entry
  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (sharpened == ($past(grad_mag, 8) >= $past(gradient_threshold, 8))))
    else $error("sharpened flag does not match threshold test");

  // pass-through pixels come out exactly as they went in
  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    (done && !sharpened) |-> (out_red == $past(orig_red, 8) &&
                              out_green == $past(orig_green, 8) &&
                              out_blue == $past(orig_blue, 8)))
    else $error("pass-through pixel altered");

endmodule

/* design/usm_ycc_to_rgb.sv */
// Back conversion of sharpened luma plus original chroma to RGB, three stages.
`timescale 1ns / 1ps

module usm_ycc_to_rgb import usm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  usm_meta_t         in_meta,
  input  logic [7:0]        luma,
  input  logic signed [8:0] dcb,
  input  logic signed [8:0] dcr,
  output logic              done,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic              sharpened
);

  // stage A: products
  logic               va;
  usm_meta_t          ma;
  logic signed [23:0] ya, r_cr, g_cb, g_cr, b_cb;
  // stage B: sums
  logic               vb;
  usm_meta_t          mb;
  logic signed [23:0] sum_r, sum_g, sum_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      done <= 1'b0;
    end else begin
      va   <= in_valid;
      vb   <= va;
      done <= vb;
    end
  end

  always_ff @(posedge clk) begin
    ma    <= in_meta;
    ya    <= $signed(24'({luma, 12'b0}));
    r_cr  <= mul_ch(dcr, K_R_CR);
    g_cb  <= mul_ch(dcb, K_G_CB);
    g_cr  <= mul_ch(dcr, K_G_CR);
    b_cb  <= mul_ch(dcb, K_B_CB);

    mb    <= ma;
    sum_r <= ya + r_cr;
    sum_g <= ya - g_cb - g_cr;
    sum_b <= ya + b_cb;

    // pass-through pixels keep their original color
    sharpened <= mb.sharp;
    if (mb.sharp) begin
      out_red   <= rnd_clip(sum_r, FRAC_BITS);
      out_green <= rnd_clip(sum_g, FRAC_BITS);
      out_blue  <= rnd_clip(sum_b, FRAC_BITS);
    end else begin
      out_red   <= mb.red;
      out_green <= mb.green;
      out_blue  <= mb.blue;
    end
  end

endmodule

/* bench/unsharp_mask_ycbcr_pixel_unit_chk.sv */
// Scoreboard for the unsharp mask pixel unit: predicts every pixel beat and checks results.
`timescale 1ns / 1ps

module unsharp_mask_ycbcr_pixel_unit_chk import usm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  orig_red,
  input  logic [7:0]  orig_green,
  input  logic [7:0]  orig_blue,
  input  logic [7:0]  blur_red,
  input  logic [7:0]  blur_green,
  input  logic [7:0]  blur_blue,
  input  logic [7:0]  grad_mag,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        done,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        sharpened,
  output int          fail_count,
  output int          outstanding,
  output int          checked,
  output int          sharp_seen
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       sharp;
  } pixel_res_t;

  logic [11:0] gain_q;
  logic [7:0]  thr_q;
  pixel_res_t  expected_pixels[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    checked     = 0;
    sharp_seen  = 0;
  end

  // v / 2^sh, nearest, ties away from zero
  function automatic longint div_round(input longint v, input int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint sat8(input longint v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic void rgb_to_ycc(input longint r, input longint g, input longint b,
                                     output longint y, output longint cb,
                                     output longint cr);
    y  = sat8(div_round(1225 * r + 2404 * g + 467 * b, 12));
    cb = sat8(div_round(-692 * r - 1356 * g + 2048 * b + 127 * 4096, 12));
    cr = sat8(div_round(2048 * r - 1716 * g - 332 * b + 127 * 4096, 12));
  endfunction

  function automatic pixel_res_t sharpen_pixel(input logic [7:0] o_r, input logic [7:0] o_g,
                                               input logic [7:0] o_b, input logic [7:0] b_r,
                                               input logic [7:0] b_g, input logic [7:0] b_b,
                                               input logic [7:0] grad);
    pixel_res_t res;
    longint yo, cbo, cro, yb, cbb, crb, luma, dcb, dcr, g;
    if (grad < thr_q) begin
      res = '{red: o_r, green: o_g, blue: o_b, sharp: 1'b0};
      return res;
    end
    g = longint'(gain_q);
    rgb_to_ycc(longint'(o_r), longint'(o_g), longint'(o_b), yo, cbo, cro);
    rgb_to_ycc(longint'(b_r), longint'(b_g), longint'(b_b), yb, cbb, crb);
    luma = sat8(div_round(yo * 256 + g * (yo - yb), 8));
    dcb = cbo - 127;
    dcr = cro - 127;
    res.red   = 8'(sat8(div_round(luma * 4096 + 5734 * dcr, 12)));
    res.green = 8'(sat8(div_round(luma * 4096 - 1405 * dcb - 2912 * dcr, 12)));
    res.blue  = 8'(sat8(div_round(luma * 4096 + 7229 * dcb, 12)));
    res.sharp = 1'b1;
    return res;
  endfunction

  function automatic void note_failure(input string what, input pixel_res_t want,
                                       input pixel_res_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected r=%0d g=%0d b=%0d sharp=%0b, got r=%0d g=%0d b=%0d sharp=%0b",
               $realtime, what, want.red, want.green, want.blue, want.sharp,
               got.red, got.green, got.blue, got.sharp);
  endfunction

  always @(posedge clk) begin : watch
    pixel_res_t got;
    pixel_res_t want;
    if (rst) begin
      gain_q <= GAIN_RESET;
      thr_q  <= THRESHOLD_RESET;
      expected_pixels.delete();
    end else begin
      if (done) begin
        got = '{red: out_red, green: out_green, blue: out_blue, sharp: sharpened};
        if (expected_pixels.size() == 0) begin
          note_failure("result beat with nothing pending", '0, got);
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (got.sharp === 1'b1) sharp_seen++;
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.sharp !== want.sharp)
            note_failure("result beat differs", want, got);
        end
      end
      if (start && !busy)
        expected_pixels.push_back(sharpen_pixel(orig_red, orig_green, orig_blue,
                                                blur_red, blur_green, blur_blue, grad_mag));
      if (cfg_write) begin
        case (cfg_index)
          CFG_GAIN: begin
            gain_q <= cfg_data;
          end
          CFG_THRESHOLD: begin
            thr_q <= cfg_data[7:0];
          end
        endcase
      end
    end
    outstanding <= expected_pixels.size();
  end

endmodule

/* bench/unsharp_mask_ycbcr_pixel_unit_tb.sv */
// Testbench top for the unsharp mask pixel unit: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module unsharp_mask_ycbcr_pixel_unit_tb;
  import usm_pkg::*;

  // This only catches a hang.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_PIXELS = 75;
  localparam int PHASES       = 6;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  orig_red, orig_green, orig_blue;
  logic [7:0]  blur_red, blur_green, blur_blue;
  logic [7:0]  grad_mag;
  logic        cfg_write;
  logic        cfg_index;
  logic [11:0] cfg_data;
  logic        done;
  logic [7:0]  out_red, out_green, out_blue;
  logic        sharpened;

  int fail_count, outstanding, checked, sharp_seen;
  int cycles;
  int idle_pct;     // chance in percent that the sender skips a given cycle
  int settings;     // register settings the run went through
  logic [7:0] thr_now;

  unsharp_mask_ycbcr_pixel_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .orig_red   (orig_red),
    .orig_green (orig_green),
    .orig_blue  (orig_blue),
    .blur_red   (blur_red),
    .blur_green (blur_green),
    .blur_blue  (blur_blue),
    .grad_mag   (grad_mag),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .sharpened  (sharpened)
  );

  // Scoreboard sits beside the DUT and sees the same pins
  unsharp_mask_ycbcr_pixel_unit_chk u_chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .orig_red    (orig_red),
    .orig_green  (orig_green),
    .orig_blue   (orig_blue),
    .blur_red    (blur_red),
    .blur_green  (blur_green),
    .blur_blue   (blur_blue),
    .grad_mag    (grad_mag),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .sharpened   (sharpened),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .sharp_seen  (sharp_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hang guard
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("unsharp_mask_ycbcr_pixel_unit: mismatch");
      $finish;
    end
  end

  // One pixel beat. start stays high on return: the next beat or a gap decides
  // whether it drops, so start never gets two updates in one step.
  task automatic drive_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] br, input logic [7:0] bg, input logic [7:0] bb,
                             input logic [7:0] gm);
    start      <= 1'b1;
    orig_red   <= r;
    orig_green <= g;
    orig_blue  <= b;
    blur_red   <= br;
    blur_green <= bg;
    blur_blue  <= bb;
    grad_mag   <= gm;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random sender bubbles, geometric length
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off the sender until every pending pixel is back. The first edge lets
  // the scoreboard count the beat accepted on the current edge.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Registers change only with the pipe empty
  task automatic write_reg(input logic idx, input logic [11:0] val);
    drain();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_regs(input logic [11:0] gain, input logic [7:0] thr);
    write_reg(CFG_GAIN, gain);
    // junk in the unused upper data bits of the threshold write
    write_reg(CFG_THRESHOLD, {4'($urandom), thr});
    thr_now = thr;
    settings++;
  endtask

  // Mostly natural pixels (blur close to the original), plus wide swings,
  // saturated corners and flat areas; gradient clustered on the threshold.
  task automatic random_pixel();
    logic [7:0] o[3];
    logic [7:0] bl[3];
    logic [7:0] gm;
    int kind, v, i, gsel;
    kind = $urandom_range(9);
    for (i = 0; i < 3; i++) begin
      o[i] = 8'($urandom_range(255));
      if (kind <= 5) begin
        v = int'(o[i]) + int'($urandom_range(48)) - 24;
        bl[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
      end else if (kind <= 7) begin
        bl[i] = 8'($urandom_range(255));
      end else if (kind == 8) begin
        o[i]  = $urandom_range(1) ? 8'd255 : 8'd0;
        bl[i] = $urandom_range(1) ? 8'd255 : 8'd0;
      end else begin
        bl[i] = o[i];
      end
    end
    gsel = $urandom_range(3);
    if (gsel == 0)
      gm = thr_now;
    else if (gsel == 1)
      gm = (thr_now == 0) ? 8'd0 : thr_now - 8'd1;
    else
      gm = 8'($urandom_range(255));
    drive_pixel(o[0], o[1], o[2], bl[0], bl[1], bl[2], gm);
  endtask

  initial begin : stimulus
    int p, n;
    rst        = 1'b1;
    start      = 1'b0;
    orig_red   = '0;
    orig_green = '0;
    orig_blue  = '0;
    blur_red   = '0;
    blur_green = '0;
    blur_blue  = '0;
    grad_mag   = '0;
    cfg_write  = 1'b0;
    cfg_index  = CFG_GAIN;
    cfg_data   = '0;
    idle_pct   = 0;
    settings   = 1;
    thr_now    = THRESHOLD_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset values (gain 1.0, threshold 0): extremes and saturation
    drive_pixel(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    drive_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    drive_pixel(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd77);  // luma clips high
    drive_pixel(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd3);   // luma clips low
    drive_pixel(8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd10);  // red out of range
    drive_pixel(8'd0,   8'd0,   8'd255, 8'd128, 8'd128, 8'd128, 8'd200);
    drive_pixel(8'd0,   8'd255, 8'd0,   8'd40,  8'd200, 8'd40,  8'd128);
    drive_pixel(8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd1);

    // Max gain, mid threshold: below, equal and above the threshold
    set_regs(12'd4095, 8'd128);
    drive_pixel(8'd90,  8'd30,  8'd200, 8'd0,   8'd0,   8'd0,   8'd127); // passes through
    drive_pixel(8'd90,  8'd30,  8'd200, 8'd100, 8'd40,  8'd190, 8'd128); // equal: sharpened
    drive_pixel(8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd0);
    drive_pixel(8'd12,  8'd240, 8'd66,  8'd20,  8'd230, 8'd70,  8'd255);
    drive_pixel(8'd200, 8'd100, 8'd50,  8'd190, 8'd110, 8'd40,  8'd200);
    drive_pixel(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd128);

    // Zero gain, top threshold: only a gradient of 255 gets through
    set_regs(12'd0, 8'd255);
    drive_pixel(8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255);
    drive_pixel(8'd17,  8'd200, 8'd90,  8'd255, 8'd255, 8'd255, 8'd254);
    drive_pixel(8'd17,  8'd200, 8'd90,  8'd255, 8'd255, 8'd255, 8'd255);

    // Random phases: register corners first, then random settings.
    // Sender idles 11% in phases 0-1, 64% in 2-3, never in 4-5.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_regs(12'd0, 8'd0);
        1: set_regs(12'd4095, 8'd255);
        2: set_regs(12'($urandom_range(4095)), 8'($urandom_range(255)));
        3: set_regs(GAIN_RESET, 8'($urandom_range(255)));
        4: set_regs(12'($urandom_range(4095)), 8'd64);
        default: set_regs(12'd1, 8'($urandom_range(255)));
      endcase
      idle_pct = (p < 2) ? 11 : (p < 4) ? 64 : 0;
      for (n = 0; n < PHASE_PIXELS; n++) begin
        if (p == 4 && n == PHASE_PIXELS / 2) drain();  // full stop mid-stream
        idle_gap();
        random_pixel();
      end
    end

    // Let the pipe empty, then watch a while longer for stray done pulses
    drain();
    repeat (16) @(posedge clk);

    $display("covered %0d pixel beats (%0d sharpened, rest passed through) over %0d settings",
             checked, sharp_seen, settings);
    $display("gain 0..4095 and threshold 0..255 reached, sender idle at 0, 11 and 64 percent");
    if (fail_count == 0) begin
      $display("unsharp_mask_ycbcr_pixel_unit: match");
    end else begin
      $display("unsharp_mask_ycbcr_pixel_unit: mismatch");
    end
    $finish;
  end

endmodule

/* unsharp_mask_ycbcr_pixel_unit.f */
design/usm_pkg.sv
design/usm_ycc_to_rgb.sv
design/unsharp_mask_ycbcr_pixel_unit.sv
bench/unsharp_mask_ycbcr_pixel_unit_chk.sv
bench/unsharp_mask_ycbcr_pixel_unit_tb.sv
